FILE: rtl/cac_pkg.sv
// Shared constants, record types and helpers for the call auction clearing block.
package cac_pkg;

   localparam int MAX_ORDERS_DEF  = 64;
   localparam int CLASS_COUNT_DEF = 9;

   localparam int PRICE_W = 32;
   localparam int SEQ_W   = 16;
   localparam int CLS_W   = 4;
   localparam int SUM_W   = 40;
   localparam int FILL_W  = 17;
   localparam int FRAC_W  = 16;
   localparam int CLS_MAX = 16;

   localparam logic [SUM_W-1:0]  SUM_SAT  = {SUM_W{1'b1}};
   localparam logic [FILL_W-1:0] FILL_ONE = 17'h10000;

   // request codes
   localparam logic [1:0] REQ_BID   = 2'd0;
   localparam logic [1:0] REQ_ASK   = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   typedef struct packed {
      logic [PRICE_W-1:0] qty;
      logic [PRICE_W-1:0] price;
      logic [CLS_W-1:0]   cls;
      logic [SEQ_W-1:0]   seq;
   } bid_rec_type;

   typedef struct packed {
      logic [PRICE_W-1:0] qty;
      logic [PRICE_W-1:0] price;
      logic [SEQ_W-1:0]   seq;
   } ask_rec_type;

   function automatic logic [PRICE_W-1:0] clamp_neg(input logic signed [PRICE_W-1:0] v);
      clamp_neg = v[PRICE_W-1] ? '0 : PRICE_W'(v);
   endfunction

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[SUM_W] ? SUM_SAT : s[SUM_W-1:0];
   endfunction

endpackage

FILE: rtl/cac_if.sv
// Request and response channel interfaces.
interface cac_req_if;
   import cac_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 req_type;
   logic signed [PRICE_W-1:0]  quantity;
   logic signed [PRICE_W-1:0]  order_price;
   logic [CLS_W-1:0]           category;
   logic [SEQ_W-1:0]           sequence_req;
   logic signed [PRICE_W-1:0]  idle_price;

   modport source (output valid, req_type, quantity, order_price, category,
                   sequence_req, idle_price, input ready);
   modport sink   (input valid, req_type, quantity, order_price, category,
                   sequence_req, idle_price, output ready);
endinterface

interface cac_rsp_if;
   import cac_pkg::*;
   logic                valid;
   logic                ready;
   logic [CLS_W-1:0]    class_index;
   logic [FILL_W-1:0]   fill_ratio;
   logic [SUM_W-1:0]    class_bought;
   logic [PRICE_W-1:0]  price_cleared;
   logic [SUM_W-1:0]    total_traded;
   logic [SUM_W-1:0]    total_requested;
   logic [SUM_W-1:0]    total_offered;
   logic                last_row;

   modport source (output valid, class_index, fill_ratio, class_bought, price_cleared,
                   total_traded, total_requested, total_offered, last_row, input ready);
   modport sink   (input valid, class_index, fill_ratio, class_bought, price_cleared,
                   total_traded, total_requested, total_offered, last_row, output ready);
endinterface

FILE: rtl/cac_ram.sv
// Generic single write, single read RAM with registered read data.
module cac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/cac_div.sv
// Bit-serial restoring divider for the Q1.16 fill ratio, capped at 1.0.
module cac_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cac_pkg::SUM_W-1:0]   num,
   input  logic [cac_pkg::SUM_W-1:0]   den,
   output logic                        done,
   output logic [cac_pkg::FILL_W-1:0]  quot
);
   import cac_pkg::*;

   localparam int CNT_W = $clog2(FRAC_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  den_ff, den_in;
   logic [FILL_W-1:0] quot_ff, quot_in;
   logic [SUM_W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      trial   = {rem_ff, 1'b0};
      if (start) begin
         den_in = den;
         if (num >= den) begin
            // covers the nothing-requested case too
            quot_in = FILL_ONE;
            done_in = 1'b1;
         end else begin
            rem_in  = num;
            quot_in = '0;
            cnt_in  = CNT_W'(FRAC_W);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = SUM_W'(trial - {1'b0, den_ff});
            quot_in = {quot_ff[FILL_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[SUM_W-1:0];
            quot_in = {quot_ff[FILL_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

FILE: rtl/call_auction_clearing.sv
// Call auction clearing: order stores, best-order scanner, matcher and fill rows.
// Loads: one request a cycle while idle, ready held high; a load returns nothing.
// Clear: each best-order search scans one store through its RAM read port; each
// advance to the next bid or ask rescans, each trade updates both remainders, and
// each category row runs the divider and then the response handshake.
// Sync active-high reset empties both stores and book sums; no clearing pass.
module call_auction_clearing #(
   parameter int MAX_ORDERS  = cac_pkg::MAX_ORDERS_DEF,
   parameter int CLASS_COUNT = cac_pkg::CLASS_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cac_req_if.sink    req_ch,
   cac_rsp_if.source  rsp_ch
);
   import cac_pkg::*;

   localparam int AW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
   localparam int CW = $clog2(MAX_ORDERS + 1);
   localparam logic [CLS_W-1:0] K_LAST = CLS_W'(CLASS_COUNT - 1);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SCAN  = 7'b0000010,
      ST_MATCH = 7'b0000100,
      ST_PRICE = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_WAIT  = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   // true when key a ranks ahead of key b; asks rank low price first
   function automatic logic key_before(input logic is_ask,
                                       input logic [PRICE_W-1:0] pa,
                                       input logic [SEQ_W-1:0] sa,
                                       input logic [AW-1:0] ia,
                                       input logic [PRICE_W-1:0] pb,
                                       input logic [SEQ_W-1:0] sb,
                                       input logic [AW-1:0] ib);
      logic r;
      if (pa != pb) begin
         r = is_ask ? (pa < pb) : (pa > pb);
      end else if (sa != sb) begin
         r = sa < sb;
      end else begin
         r = ia < ib;
      end
      key_before = r;
   endfunction

   state_type state_ff, state_in;

   // order counts, load-time sums and trade results
   logic [CW-1:0]    bid_cnt_ff, bid_cnt_in, ask_cnt_ff, ask_cnt_in;
   logic [SUM_W-1:0] class_req_ff [CLS_MAX];
   logic [SUM_W-1:0] class_req_in [CLS_MAX];
   logic [SUM_W-1:0] class_trd_ff [CLS_MAX];
   logic [SUM_W-1:0] class_trd_in [CLS_MAX];
   logic [SUM_W-1:0] tot_req_ff, tot_req_in, tot_off_ff, tot_off_in;
   logic [SUM_W-1:0] traded_ff, traded_in;
   logic [PRICE_W-1:0] cleared_ff, cleared_in, mb_ff, mb_in, ma_ff, ma_in;

   // scanner: side 0 is bids, 1 is asks
   logic          side_ff, side_in, first_ff, first_in, ask_init_ff, ask_init_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic          found_ff, found_in;
   logic [PRICE_W-1:0] best_price_ff, best_price_in, best_qty_ff, best_qty_in;
   logic [SEQ_W-1:0]   best_seq_ff, best_seq_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic [CLS_W-1:0]   best_cls_ff, best_cls_in;

   // current best bid and ask in the match
   logic [PRICE_W-1:0] b_price_ff, b_price_in, brem_ff, brem_in;
   logic [SEQ_W-1:0]   b_seq_ff, b_seq_in;
   logic [AW-1:0]      b_idx_ff, b_idx_in;
   logic [CLS_W-1:0]   b_cls_ff, b_cls_in;
   logic [CW-1:0]      b_pos_ff, b_pos_in;
   logic [PRICE_W-1:0] a_price_ff, a_price_in, arem_ff, arem_in;
   logic [SEQ_W-1:0]   a_seq_ff, a_seq_in;
   logic [AW-1:0]      a_idx_ff, a_idx_in;
   logic [CW-1:0]      a_pos_ff, a_pos_in;

   // row sequencing and response register
   logic [CLS_W-1:0]   k_ff, k_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CLS_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [FILL_W-1:0]  rsp_fill_ff, rsp_fill_in;
   logic [SUM_W-1:0]   rsp_bought_ff, rsp_bought_in;
   logic [PRICE_W-1:0] rsp_price_ff, rsp_price_in;
   logic [SUM_W-1:0]   rsp_trd_ff, rsp_trd_in, rsp_req_ff, rsp_req_in;
   logic [SUM_W-1:0]   rsp_off_ff, rsp_off_in;
   logic               rsp_last_ff, rsp_last_in;

   // RAM and divider hookup
   logic        bid_we, ask_we;
   bid_rec_type bid_wr, bid_rd;
   ask_rec_type ask_wr, ask_rd;
   logic        div_start, div_done;
   logic [FILL_W-1:0] div_quot;

   logic [PRICE_W-1:0] in_qty, in_price;
   logic               accept;
   logic [CW-1:0]      scan_n;
   logic [PRICE_W-1:0] cand_price, cand_qty, last_price, q_min;
   logic [SEQ_W-1:0]   cand_seq, last_seq;
   logic [AW-1:0]      last_idx;
   logic               qualify;
   logic [PRICE_W:0]   mid_sum;

   assign in_qty   = clamp_neg(req_ch.quantity);
   assign in_price = clamp_neg(req_ch.order_price);
   assign accept   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   assign bid_wr = '{qty: in_qty, price: in_price, cls: req_ch.category,
                     seq: req_ch.sequence_req};
   assign ask_wr = '{qty: in_qty, price: in_price, seq: req_ch.sequence_req};

   cac_ram #(.WIDTH($bits(bid_rec_type)), .DEPTH(MAX_ORDERS)) u_bid_ram (
      .clock   (clock),
      .wr_en   (bid_we),
      .wr_addr (bid_cnt_ff[AW-1:0]),
      .wr_data (bid_wr),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (bid_rd)
   );

   cac_ram #(.WIDTH($bits(ask_rec_type)), .DEPTH(MAX_ORDERS)) u_ask_ram (
      .clock   (clock),
      .wr_en   (ask_we),
      .wr_addr (ask_cnt_ff[AW-1:0]),
      .wr_data (ask_wr),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (ask_rd)
   );

   cac_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (class_trd_ff[k_ff]),
      .den   (class_req_ff[k_ff]),
      .done  (div_done),
      .quot  (div_quot)
   );

   // shared compare unit: candidate must rank after the last pick and ahead of best
   assign scan_n     = side_ff ? ask_cnt_ff : bid_cnt_ff;
   assign cand_price = side_ff ? ask_rd.price : bid_rd.price;
   assign cand_qty   = side_ff ? ask_rd.qty : bid_rd.qty;
   assign cand_seq   = side_ff ? ask_rd.seq : bid_rd.seq;
   assign last_price = side_ff ? a_price_ff : b_price_ff;
   assign last_seq   = side_ff ? a_seq_ff : b_seq_ff;
   assign last_idx   = side_ff ? a_idx_ff : b_idx_ff;
   assign qualify    = first_ff || key_before(side_ff, last_price, last_seq, last_idx,
                                              cand_price, cand_seq, rd_idx_ff);
   assign q_min      = (brem_ff < arem_ff) ? brem_ff : arem_ff;
   assign mid_sum    = {1'b0, mb_ff} + {1'b0, ma_ff};

   always_comb begin
      state_in      = state_ff;
      bid_cnt_in    = bid_cnt_ff;
      ask_cnt_in    = ask_cnt_ff;
      class_req_in  = class_req_ff;
      class_trd_in  = class_trd_ff;
      tot_req_in    = tot_req_ff;
      tot_off_in    = tot_off_ff;
      traded_in     = traded_ff;
      cleared_in    = cleared_ff;
      mb_in         = mb_ff;
      ma_in         = ma_ff;
      side_in       = side_ff;
      first_in      = first_ff;
      ask_init_in   = ask_init_ff;
      addr_in       = addr_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      found_in      = found_ff;
      best_price_in = best_price_ff;
      best_qty_in   = best_qty_ff;
      best_seq_in   = best_seq_ff;
      best_idx_in   = best_idx_ff;
      best_cls_in   = best_cls_ff;
      b_price_in    = b_price_ff;
      brem_in       = brem_ff;
      b_seq_in      = b_seq_ff;
      b_idx_in      = b_idx_ff;
      b_cls_in      = b_cls_ff;
      b_pos_in      = b_pos_ff;
      a_price_in    = a_price_ff;
      arem_in       = arem_ff;
      a_seq_in      = a_seq_ff;
      a_idx_in      = a_idx_ff;
      a_pos_in      = a_pos_ff;
      k_in          = k_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_bought_in = rsp_bought_ff;
      rsp_price_in  = rsp_price_ff;
      rsp_trd_in    = rsp_trd_ff;
      rsp_req_in    = rsp_req_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_last_in   = rsp_last_ff;
      bid_we        = 1'b0;
      ask_we        = 1'b0;
      div_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_ch.req_type)
                  REQ_BID: begin
                     if (bid_cnt_ff < CW'(MAX_ORDERS)) begin
                        bid_we     = 1'b1;
                        bid_cnt_in = bid_cnt_ff + 1'b1;
                        tot_req_in = sat_add(tot_req_ff, SUM_W'(in_qty));
                        if ({1'b0, req_ch.category} < (CLS_W + 1)'(CLASS_COUNT)) begin
                           class_req_in[req_ch.category] =
                              sat_add(class_req_ff[req_ch.category], SUM_W'(in_qty));
                        end
                     end
                  end
                  REQ_ASK: begin
                     if (ask_cnt_ff < CW'(MAX_ORDERS)) begin
                        ask_we     = 1'b1;
                        ask_cnt_in = ask_cnt_ff + 1'b1;
                        tot_off_in = sat_add(tot_off_ff, SUM_W'(in_qty));
                     end
                  end
                  REQ_CLEAR: begin
                     cleared_in  = clamp_neg(req_ch.idle_price);
                     traded_in   = '0;
                     b_pos_in    = '0;
                     a_pos_in    = '0;
                     ask_init_in = 1'b0;
                     if (bid_cnt_ff != '0 && ask_cnt_ff != '0) begin
                        side_in  = 1'b0;
                        first_in = 1'b1;
                        addr_in  = '0;
                        found_in = 1'b0;
                        state_in = ST_SCAN;
                     end else begin
                        state_in = ST_PRICE;
                     end
                  end
                  default: begin
                     // unknown request: dropped
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (addr_ff < scan_n) begin
               addr_in   = addr_ff + 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = addr_ff[AW-1:0];
            end
            if (rd_vld_ff && qualify &&
                (!found_ff || key_before(side_ff, cand_price, cand_seq, rd_idx_ff,
                                         best_price_ff, best_seq_ff, best_idx_ff))) begin
               found_in      = 1'b1;
               best_price_in = cand_price;
               best_qty_in   = cand_qty;
               best_seq_in   = cand_seq;
               best_idx_in   = rd_idx_ff;
               best_cls_in   = bid_rd.cls;
            end
            if (addr_ff == scan_n && !rd_vld_ff) begin
               if (side_ff) begin
                  a_price_in = best_price_ff;
                  arem_in    = best_qty_ff;
                  a_seq_in   = best_seq_ff;
                  a_idx_in   = best_idx_ff;
               end else begin
                  b_price_in = best_price_ff;
                  brem_in    = best_qty_ff;
                  b_seq_in   = best_seq_ff;
                  b_idx_in   = best_idx_ff;
                  b_cls_in   = best_cls_ff;
               end
               if (!ask_init_ff) begin
                  // opening pass: find the best ask after the best bid
                  ask_init_in = 1'b1;
                  side_in     = 1'b1;
                  first_in    = 1'b1;
                  addr_in     = '0;
                  found_in    = 1'b0;
               end else begin
                  state_in = ST_MATCH;
               end
            end
         end

         ST_MATCH: begin
            if (b_price_ff < a_price_ff) begin
               state_in = ST_PRICE;
            end else if (brem_ff == '0) begin
               b_pos_in = b_pos_ff + 1'b1;
               if (b_pos_ff + 1'b1 < bid_cnt_ff) begin
                  side_in  = 1'b0;
                  first_in = 1'b0;
                  addr_in  = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_PRICE;
               end
            end else if (arem_ff == '0) begin
               a_pos_in = a_pos_ff + 1'b1;
               if (a_pos_ff + 1'b1 < ask_cnt_ff) begin
                  side_in  = 1'b1;
                  first_in = 1'b0;
                  addr_in  = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_PRICE;
               end
            end else begin
               // one trade of the smaller remainder
               if ({1'b0, b_cls_ff} < (CLS_W + 1)'(CLASS_COUNT)) begin
                  class_trd_in[b_cls_ff] = sat_add(class_trd_ff[b_cls_ff], SUM_W'(q_min));
               end
               traded_in = sat_add(traded_ff, SUM_W'(q_min));
               brem_in   = brem_ff - q_min;
               arem_in   = arem_ff - q_min;
               mb_in     = b_price_ff;
               ma_in     = a_price_ff;
            end
         end

         ST_PRICE: begin
            if (traded_ff != '0) begin
               cleared_in = mid_sum[PRICE_W:1];
            end
            k_in     = '0;
            state_in = ST_DIV;
         end

         ST_DIV: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end

         ST_WAIT: begin
            if (div_done) begin
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = k_ff;
               rsp_fill_in   = div_quot;
               rsp_bought_in = class_trd_ff[k_ff];
               rsp_price_in  = cleared_ff;
               rsp_trd_in    = traded_ff;
               rsp_req_in    = tot_req_ff;
               rsp_off_in    = tot_off_ff;
               rsp_last_in   = (k_ff == K_LAST);
               state_in      = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               if (k_ff == K_LAST) begin
                  // book empties after the last row
                  bid_cnt_in = '0;
                  ask_cnt_in = '0;
                  tot_req_in = '0;
                  tot_off_in = '0;
                  for (int i = 0; i < CLS_MAX; i++) begin
                     class_req_in[i] = '0;
                     class_trd_in[i] = '0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_DIV;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bid_cnt_ff   <= '0;
         ask_cnt_ff   <= '0;
         tot_req_ff   <= '0;
         tot_off_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ask_init_ff  <= 1'b0;
         found_ff     <= 1'b0;
         for (int i = 0; i < CLS_MAX; i++) begin
            class_req_ff[i] <= '0;
            class_trd_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         bid_cnt_ff   <= bid_cnt_in;
         ask_cnt_ff   <= ask_cnt_in;
         tot_req_ff   <= tot_req_in;
         tot_off_ff   <= tot_off_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         ask_init_ff  <= ask_init_in;
         found_ff     <= found_in;
         class_req_ff <= class_req_in;
         class_trd_ff <= class_trd_in;
      end
      traded_ff     <= traded_in;
      cleared_ff    <= cleared_in;
      mb_ff         <= mb_in;
      ma_ff         <= ma_in;
      side_ff       <= side_in;
      first_ff      <= first_in;
      addr_ff       <= addr_in;
      rd_idx_ff     <= rd_idx_in;
      best_price_ff <= best_price_in;
      best_qty_ff   <= best_qty_in;
      best_seq_ff   <= best_seq_in;
      best_idx_ff   <= best_idx_in;
      best_cls_ff   <= best_cls_in;
      b_price_ff    <= b_price_in;
      brem_ff       <= brem_in;
      b_seq_ff      <= b_seq_in;
      b_idx_ff      <= b_idx_in;
      b_cls_ff      <= b_cls_in;
      b_pos_ff      <= b_pos_in;
      a_price_ff    <= a_price_in;
      arem_ff       <= arem_in;
      a_seq_ff      <= a_seq_in;
      a_idx_ff      <= a_idx_in;
      a_pos_ff      <= a_pos_in;
      k_ff          <= k_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_bought_ff <= rsp_bought_in;
      rsp_price_ff  <= rsp_price_in;
      rsp_trd_ff    <= rsp_trd_in;
      rsp_req_ff    <= rsp_req_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.class_index     = rsp_idx_ff;
   assign rsp_ch.fill_ratio      = rsp_fill_ff;
   assign rsp_ch.class_bought    = rsp_bought_ff;
   assign rsp_ch.price_cleared   = rsp_price_ff;
   assign rsp_ch.total_traded    = rsp_trd_ff;
   assign rsp_ch.total_requested = rsp_req_ff;
   assign rsp_ch.total_offered   = rsp_off_ff;
   assign rsp_ch.last_row        = rsp_last_ff;
endmodule
